// ===== rtl/ssmvp_pkg.sv =====
package ssmvp_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 256;
    localparam int KEY_BITS_DEF   = 12;
    localparam int COEFF_BITS_DEF = 16;

    localparam int MEAS_W     = 48;
    localparam int VALUE_W    = 16;
    localparam int SLOT_W     = 8;
    localparam int MAP_W      = SLOT_W + 1;
    localparam int NUM_ROWS_W = 7;
    localparam int NUM_COLS_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [1:0] {
        OP_COEFF = 2'd0,
        OP_MAP   = 2'd1,
        OP_ELEM  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SETTLE,
        ST_MAC,
        ST_FLUSH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [5:0]                row;
        logic [7:0]                column;
        logic signed [15:0]        coefficient;
        logic [11:0]               key;
        logic [SLOT_W-1:0]         slot;
        logic                      slot_valid;
        logic signed [VALUE_W-1:0] element_value;
        logic                      last;
    } t_in_word;

    typedef struct packed {
        logic signed [MEAS_W-1:0] measurement;
        logic [5:0]               row_index;
        logic                     last_row;
        logic                     missing_key;
    } t_out_word;

endpackage

// ===== rtl/sparse_scatter_matvec_projector.sv =====
// Sparse scatter matrix-vector projector.
// Input channel (i_in_valid / o_in_stall / i_in_word) takes load words and
// sparse element words. Coefficient and map writes and non-last elements
// are taken one per cycle. An element with last set starts the multiply:
// the input stalls until every row result of the frame has been handed to
// the output register.
// Output channel (o_out_valid / i_out_stall / o_out_word) gives one word per
// row in use, row 0 first, last_row set on the final one.
// After the last element the sequencer passes a settle state; then each
// row sweeps its columns one per cycle through the coefficient and dense
// vector memory read ports into a multiply register and the accumulator,
// waits in a flush state for the pipeline to empty, and loads the result
// in an emit state. The last row sweeps max(num_cols, highest written
// column + 1) columns, zeroing the dense vector behind it.
// Reset: a clearing pass over max(2^KEY_BITS, MAX_COLS) addresses (4096 at the
// defaults) invalidates the key map and zeroes the dense vector; the input
// stalls meanwhile, configuration writes are taken at all times.
// A stalled receiver holds the output word; the row sequencer waits on it
// and new input words are taken while the last result is still waiting.
module sparse_scatter_matvec_projector
    import ssmvp_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int COEFF_BITS = COEFF_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RB        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CDEPTH    = MAX_ROWS * MAX_COLS;
    localparam int CA_W      = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int MAP_DEPTH = 1 << KEY_BITS;
    localparam int CLR_N     = (MAP_DEPTH > MAX_COLS) ? MAP_DEPTH : MAX_COLS;
    localparam int CLR_W     = $clog2(CLR_N);
    localparam int PROD_W    = COEFF_BITS + VALUE_W;
    localparam int ACC_W     = PROD_W + CB + 1;
    localparam int SUM_W     = (ACC_W > MEAS_W) ? ACC_W : MEAS_W;

    // memories
    logic [COEFF_BITS-1:0]     coeff_mem [CDEPTH];
    logic [MAP_W-1:0]          map_mem   [MAP_DEPTH];
    logic signed [VALUE_W-1:0] dense_mem [MAX_COLS];

    t_state r_state, n_state;

    logic [NUM_ROWS_W-1:0] r_num_rows;
    logic [NUM_COLS_W-1:0] r_num_cols;
    logic [RB:0]           rows_eff;
    logic [CB:0]           cols_eff;

    // element stage
    logic                      r_s1_valid;
    logic signed [VALUE_W-1:0] r_s1_value;
    logic [MAP_W-1:0]          r_map_q;
    logic                      r_frame_error;
    logic [CB:0]               r_dirty_end;

    // row sequencer
    logic [RB-1:0]   r_row;
    logic [CA_W-1:0] r_row_base;
    logic [CB-1:0]   r_col;
    logic [CLR_W:0]  r_clr;

    // multiply pipeline
    logic                         r_p1_valid, r_p1_use;
    logic                         r_p2_valid, r_p2_use;
    logic signed [COEFF_BITS-1:0] r_coeff_q;
    logic signed [VALUE_W-1:0]    r_dense_q;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [SUM_W-1:0]      r_acc;

    logic      r_out_valid;
    t_out_word r_out_word;

    // control from the state decode
    logic in_stall, mac_issue, emit_wait, clearing;

    logic            in_accept;
    logic [KEY_BITS-1:0] key_idx;
    logic [KEY_BITS+11:0] key_wide;
    logic [COEFF_BITS+15:0] coef_wide;
    logic [CA_W-1:0] coef_addr;
    logic            coef_we;
    logic            is_last_row;
    logic [CB:0]     span;
    logic            col_done;
    logic            emit_load;
    logic            s1_hit, s1_we;
    logic [CB+7:0]   slot_wide;
    logic [CB-1:0]   s1_idx;
    logic            dense_we;
    logic [CB-1:0]   dense_wa;
    logic signed [VALUE_W-1:0] dense_wd;
    logic            map_we;
    logic [KEY_BITS-1:0] map_wa;
    logic [MAP_W-1:0] map_wd;
    logic [CA_W-1:0] issue_addr;
    logic [RB+5:0]   row_wide;
    logic signed [MEAS_W-1:0] meas_sat;
    logic [SUM_W-MEAS_W:0]    acc_top;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= NUM_ROWS_W'(1);
            r_num_cols <= NUM_COLS_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data[NUM_ROWS_W-1:0];
                CFG_NUM_COLS: r_num_cols <= i_cfg_data[NUM_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_num_rows == '0) begin
            rows_eff = (RB+1)'(1);
        end else if (int'(r_num_rows) > MAX_ROWS) begin
            rows_eff = (RB+1)'(MAX_ROWS);
        end else begin
            rows_eff = (RB+1)'(r_num_rows);
        end
        if (r_num_cols == '0) begin
            cols_eff = (CB+1)'(1);
        end else if (int'(r_num_cols) > MAX_COLS) begin
            cols_eff = (CB+1)'(MAX_COLS);
        end else begin
            cols_eff = (CB+1)'(r_num_cols);
        end
    end

    // state decode
    assign is_last_row = ({1'b0, r_row} + 1'b1) == (RB+1)'(rows_eff);
    assign span = (is_last_row && (r_dirty_end > cols_eff)) ? r_dirty_end : cols_eff;
    assign col_done = ({1'b0, r_col} + 1'b1) == span;
    assign emit_load = (r_state == ST_EMIT) && !emit_wait;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == (CLR_W+1)'(CLR_N - 1)) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (in_accept && (i_in_word.opcode == OP_ELEM) && i_in_word.last) begin
                    n_state = ST_SETTLE;
                end
            end
            ST_SETTLE: n_state = ST_MAC;
            ST_MAC: begin
                if (col_done) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!r_p1_valid && !r_p2_valid) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!emit_wait) n_state = is_last_row ? ST_RUN : ST_MAC;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        in_stall  = 1'b1;
        mac_issue = 1'b0;
        clearing  = 1'b0;
        emit_wait = 1'b0;
        unique case (r_state)
            ST_CLEAR:  clearing = 1'b1;
            ST_RUN:    in_stall = 1'b0;
            ST_MAC:    mac_issue = 1'b1;
            ST_EMIT:   emit_wait = r_out_valid && i_out_stall;
            default: ;
        endcase
    end

    assign o_in_stall = in_stall;
    assign in_accept  = i_in_valid && !in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + 1'b1;
        end
    end

    // input word decode
    assign key_wide  = {{KEY_BITS{1'b0}}, i_in_word.key};
    assign key_idx   = key_wide[KEY_BITS-1:0];
    assign coef_wide = {{COEFF_BITS{i_in_word.coefficient[15]}}, i_in_word.coefficient};
    assign coef_addr = CA_W'(int'(i_in_word.row) * MAX_COLS + int'(i_in_word.column));
    assign coef_we   = in_accept && (i_in_word.opcode == OP_COEFF)
                       && (int'(i_in_word.row) < MAX_ROWS)
                       && (int'(i_in_word.column) < MAX_COLS);

    // coefficient memory
    assign issue_addr = r_row_base + CA_W'(r_col);

    always_ff @(posedge i_clk) begin
        if (coef_we) coeff_mem[coef_addr] <= coef_wide[COEFF_BITS-1:0];
        if (mac_issue) r_coeff_q <= coeff_mem[issue_addr];
    end

    // key map memory, cleared after reset
    always_comb begin
        map_we = 1'b0;
        map_wa = key_idx;
        map_wd = i_in_word.slot_valid ? {1'b1, i_in_word.slot} : '0;
        if (clearing) begin
            map_we = {1'b0, r_clr} < (CLR_W+2)'(MAP_DEPTH);
            map_wa = KEY_BITS'(r_clr);
            map_wd = '0;
        end else if (in_accept && (i_in_word.opcode == OP_MAP)) begin
            map_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) map_mem[map_wa] <= map_wd;
        if (in_accept) r_map_q <= map_mem[key_idx];
    end

    // scatter stage: the map entry arrives in the cycle after the element
    assign s1_hit    = r_map_q[MAP_W-1];
    assign slot_wide = {{CB{1'b0}}, r_map_q[SLOT_W-1:0]};
    assign s1_idx    = slot_wide[CB-1:0];
    assign s1_we     = r_s1_valid && s1_hit && (int'(r_map_q[SLOT_W-1:0]) < MAX_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_frame_error <= 1'b0;
            r_dirty_end   <= '0;
        end else begin
            r_s1_valid <= in_accept && (i_in_word.opcode == OP_ELEM);
            if (emit_load && is_last_row) begin
                r_frame_error <= 1'b0;
                r_dirty_end   <= '0;
            end else begin
                if (r_s1_valid && !s1_hit) r_frame_error <= 1'b1;
                if (s1_we && ({1'b0, s1_idx} >= r_dirty_end)) begin
                    r_dirty_end <= {1'b0, s1_idx} + 1'b1;
                end
            end
        end
        if (in_accept) r_s1_value <= i_in_word.element_value;
    end

    // dense vector memory: scatter writes, zeroing after reset and on the last row sweep
    always_comb begin
        dense_we = 1'b0;
        dense_wa = s1_idx;
        dense_wd = r_s1_value;
        if (clearing) begin
            dense_we = {1'b0, r_clr} < (CLR_W+2)'(MAX_COLS);
            dense_wa = CB'(r_clr);
            dense_wd = '0;
        end else if (mac_issue) begin
            dense_we = is_last_row;
            dense_wa = r_col;
            dense_wd = '0;
        end else begin
            dense_we = s1_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dense_we) dense_mem[dense_wa] <= dense_wd;
        if (mac_issue) r_dense_q <= dense_mem[r_col];
    end

    // row and column counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_row_base <= '0;
            r_col      <= '0;
        end else begin
            if (mac_issue) r_col <= col_done ? '0 : r_col + 1'b1;
            if (emit_load) begin
                if (is_last_row) begin
                    r_row      <= '0;
                    r_row_base <= '0;
                end else begin
                    r_row      <= r_row + 1'b1;
                    r_row_base <= r_row_base + CA_W'(MAX_COLS);
                end
            end
        end
    end

    // multiply and accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p1_use   <= 1'b0;
            r_p2_use   <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_p1_valid <= mac_issue;
            r_p1_use   <= {1'b0, r_col} < cols_eff;
            r_p2_valid <= r_p1_valid;
            r_p2_use   <= r_p1_use;
            if (emit_load) begin
                r_acc <= '0;
            end else if (r_p2_valid && r_p2_use) begin
                r_acc <= r_acc + SUM_W'(r_prod);
            end
        end
        r_prod <= PROD_W'(r_coeff_q) * PROD_W'(r_dense_q);
    end

    // saturate to the measurement width
    assign acc_top = r_acc[SUM_W-1:MEAS_W-1];

    always_comb begin
        if ((&acc_top) || !(|acc_top)) begin
            meas_sat = r_acc[MEAS_W-1:0];
        end else if (r_acc[SUM_W-1]) begin
            meas_sat = {1'b1, {(MEAS_W-1){1'b0}}};
        end else begin
            meas_sat = {1'b0, {(MEAS_W-1){1'b1}}};
        end
    end

    assign row_wide = {6'd0, r_row};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (emit_load) begin
            r_out_word.measurement <= meas_sat;
            r_out_word.row_index   <= row_wide[5:0];
            r_out_word.last_row    <= is_last_row;
            r_out_word.missing_key <= r_frame_error;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import ssmvp_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 64;
    localparam int END_CYCLES    = 300;
    localparam int TIME_LIMIT    = 10_000_000;
    localparam int KEY_DEPTH     = 1 << KEY_BITS_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint MEAS_HI = (longint'(1) << (MEAS_W - 1)) - 1;
    localparam longint MEAS_LO = -MEAS_HI - 1;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    t_in_word              in_word    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    t_out_word             out_word;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    sparse_scatter_matvec_projector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // projection state as the block should hold it
    logic signed [COEFF_BITS_DEF-1:0] coef_mem [MAX_ROWS_DEF][MAX_COLS_DEF];
    logic [MAP_W-1:0]                 key_slot_map [KEY_DEPTH];
    logic signed [VALUE_W-1:0]        dense_val [MAX_COLS_DEF];
    logic                             frame_missing;
    logic [NUM_ROWS_W-1:0]            rows_setting;
    logic [NUM_COLS_W-1:0]            cols_setting;
    t_out_word                        row_results_due [$];

    // stimulus side
    t_in_word words_to_send [$];
    bit       coef_loaded [MAX_ROWS_DEF][MAX_COLS_DEF];
    bit       gen_map_valid [KEY_DEPTH];
    int       live_keys [$];
    int       phase_rows, phase_cols;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       hold_request   = 0;
    int       hold_count     = 0;

    int words_queued    = 0;
    int words_accepted  = 0;
    int results_checked = 0;
    int frames_run      = 0;
    int missing_frames  = 0;
    int settings_used   = 0;
    int fail_count      = 0;
    t_out_word due_word;

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void project_word(input t_in_word w);
        logic [MAP_W-1:0] entry;
        int nrows, ncols;
        longint acc;
        t_out_word res;
        case (w.opcode)
            OP_COEFF: coef_mem[w.row][w.column] = w.coefficient;
            OP_MAP:   key_slot_map[w.key] = w.slot_valid ? {1'b1, w.slot} : '0;
            OP_ELEM: begin
                entry = key_slot_map[w.key];
                if (!entry[SLOT_W]) frame_missing = 1'b1;
                else dense_val[entry[SLOT_W-1:0]] = w.element_value;
                if (w.last) begin
                    nrows = clamp_dim(int'(rows_setting), MAX_ROWS_DEF);
                    ncols = clamp_dim(int'(cols_setting), MAX_COLS_DEF);
                    frames_run++;
                    if (frame_missing) missing_frames++;
                    for (int r = 0; r < nrows; r++) begin
                        acc = 0;
                        for (int c = 0; c < ncols; c++)
                            acc += longint'(coef_mem[r][c]) * longint'(dense_val[c]);
                        if (acc > MEAS_HI) acc = MEAS_HI;
                        if (acc < MEAS_LO) acc = MEAS_LO;
                        res.measurement = acc[MEAS_W-1:0];
                        res.row_index   = r[5:0];
                        res.last_row    = (r == nrows - 1);
                        res.missing_key = frame_missing;
                        row_results_due.push_back(res);
                    end
                    for (int c = 0; c < MAX_COLS_DEF; c++) dense_val[c] = '0;
                    frame_missing = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // driver: one word offered at a time, held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                project_word(in_word);
                words_accepted++;
            end
            if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_word  <= words_to_send.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (row_results_due.size() == 0) begin
                    $error("unexpected row result: row_index %0d measurement %0d",
                           out_word.row_index, out_word.measurement);
                    fail_count++;
                end else begin
                    due_word = row_results_due.pop_front();
                    results_checked++;
                    if (out_word.measurement !== due_word.measurement) begin
                        $error("measurement: expected %0d, got %0d",
                               due_word.measurement, out_word.measurement);
                        fail_count++;
                    end
                    if (out_word.row_index !== due_word.row_index) begin
                        $error("row_index: expected %0d, got %0d",
                               due_word.row_index, out_word.row_index);
                        fail_count++;
                    end
                    if (out_word.last_row !== due_word.last_row) begin
                        $error("last_row: expected %0d, got %0d",
                               due_word.last_row, out_word.last_row);
                        fail_count++;
                    end
                    if (out_word.missing_key !== due_word.missing_key) begin
                        $error("missing_key: expected %0d, got %0d",
                               due_word.missing_key, out_word.missing_key);
                        fail_count++;
                    end
                end
            end
            // long hold-off counted here so the block backs up into its input
            if (hold_count < hold_request) begin
                out_stall <= 1'b1;
                hold_count++;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic t_in_word random_word();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return t_in_word'(raw[$bits(t_in_word)-1:0]);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value16();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic void queue_word(input t_in_word w);
        if (w.opcode == OP_COEFF) coef_loaded[w.row][w.column] = 1'b1;
        if (w.opcode == OP_MAP) begin
            gen_map_valid[w.key] = w.slot_valid;
            if (w.slot_valid) live_keys.push_back(w.key);
        end
        words_to_send.push_back(w);
        if (w.opcode != OP_UNUSED) words_queued++;
    endfunction

    function automatic void queue_coeff(int r, int c, logic signed [VALUE_W-1:0] v);
        t_in_word w;
        w = random_word();
        w.opcode      = OP_COEFF;
        w.row         = 6'(r);
        w.column      = 8'(c);
        w.coefficient = v;
        queue_word(w);
    endfunction

    function automatic void queue_map(int key, int slot, bit present);
        t_in_word w;
        w = random_word();
        w.opcode     = OP_MAP;
        w.key        = 12'(key);
        w.slot       = 8'(slot);
        w.slot_valid = present;
        queue_word(w);
    endfunction

    function automatic void queue_elem(int key, logic signed [VALUE_W-1:0] v, bit last);
        t_in_word w;
        w = random_word();
        w.opcode        = OP_ELEM;
        w.key           = 12'(key);
        w.element_value = v;
        w.last          = last;
        queue_word(w);
    endfunction

    function automatic int live_key();
        if (live_keys.size() == 0) return $urandom_range(KEY_DEPTH - 1);
        return live_keys[$urandom_range(live_keys.size() - 1)];
    endfunction

    function automatic int absent_key();
        int k;
        k = $urandom_range(KEY_DEPTH - 1);
        for (int i = 0; i < 8 && gen_map_valid[k]; i++) k = $urandom_range(KEY_DEPTH - 1);
        return k;
    endfunction

    // mostly inside the summed columns, sometimes anywhere in the vector
    function automatic int pick_slot();
        if ($urandom_range(3) == 0) return $urandom_range(MAX_COLS_DEF - 1);
        return $urandom_range(phase_cols - 1);
    endfunction

    // every coefficient a frame reads must have been written first
    function automatic void ensure_coeffs();
        for (int r = 0; r < phase_rows; r++)
            for (int c = 0; c < phase_cols; c++)
                if (!coef_loaded[r][c]) queue_coeff(r, c, pick_value16());
    endfunction

    function automatic void random_frame();
        int n, pick;
        if ($urandom_range(9) == 0) queue_word(random_word());
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                queue_coeff($urandom_range(MAX_ROWS_DEF - 1), $urandom_range(MAX_COLS_DEF - 1),
                            pick_value16());
            else if (pick < 14)
                queue_map($urandom_range(1) ? live_key() : $urandom_range(KEY_DEPTH - 1),
                          pick_slot(), $urandom_range(9) != 0);
            else if (pick < 24)
                queue_elem(absent_key(), pick_value16(), 1'b0);
            else
                queue_elem(live_key(), pick_value16(), 1'b0);
        end
        queue_elem(($urandom_range(9) == 0) ? absent_key() : live_key(), pick_value16(), 1'b1);
    endfunction

    task automatic set_dims(int rows_raw, int cols_raw);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_ROWS;
        cfg_data  <= CFG_DATA_W'(rows_raw);
        @(posedge i_clk);
        cfg_index <= CFG_NUM_COLS;
        cfg_data  <= CFG_DATA_W'(cols_raw);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        rows_setting = NUM_ROWS_W'(rows_raw);
        cols_setting = NUM_COLS_W'(cols_raw);
        phase_rows = clamp_dim(int'(rows_setting), MAX_ROWS_DEF);
        phase_cols = clamp_dim(int'(cols_setting), MAX_COLS_DEF);
        settings_used++;
    endtask

    task automatic wait_drained(int extra);
        @(negedge i_clk);
        while (words_to_send.size() != 0 || in_valid || row_results_due.size() != 0)
            @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic start_phase(int send_pct, int recv_pct, int rows_raw, int cols_raw);
        wait_drained(SETTLE_CYCLES);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        set_dims(rows_raw, cols_raw);
        ensure_coeffs();
        repeat ($urandom_range(3, 6)) queue_map($urandom_range(KEY_DEPTH - 1), pick_slot(), 1'b1);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int rows_raw, int cols_raw, int n);
        int start;
        start_phase(send_pct, recv_pct, rows_raw, cols_raw);
        start = words_queued;
        while (words_queued - start < n) random_frame();
    endtask

    initial begin
        int start;
        for (int r = 0; r < MAX_ROWS_DEF; r++)
            for (int c = 0; c < MAX_COLS_DEF; c++) coef_mem[r][c] = '0;
        for (int k = 0; k < KEY_DEPTH; k++) key_slot_map[k] = '0;
        for (int c = 0; c < MAX_COLS_DEF; c++) dense_val[c] = '0;
        frame_missing = 1'b0;
        rows_setting  = NUM_ROWS_W'(1);
        cols_setting  = NUM_COLS_W'(1);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero registers clamp up to a single row and column
        set_dims(0, 0);
        queue_coeff(0, 0, 16'sh8000);
        queue_map(0, 0, 1'b1);
        queue_map(KEY_DEPTH - 1, MAX_COLS_DEF - 1, 1'b1);
        queue_elem(0, 16'sh7fff, 1'b1);
        queue_word(random_word() | {2'b11, 68'd0});
        // column outside the summed range, then a duplicate overwrite
        queue_elem(KEY_DEPTH - 1, 16'sh8000, 1'b0);
        queue_elem(0, 16'sh8000, 1'b0);
        queue_elem(0, 16'sh0001, 1'b1);
        queue_elem(123, 16'sh0005, 1'b1);
        queue_map(0, 0, 1'b0);
        queue_elem(0, 16'sh0007, 1'b1);
        queue_coeff(0, 0, 16'sh7fff);
        queue_map(0, 0, 1'b1);
        queue_elem(0, 16'sh8000, 1'b1);

        // rows beyond the top clamp to all rows
        wait_drained(SETTLE_CYCLES);
        set_dims(127, 1);
        ensure_coeffs();
        queue_coeff(MAX_ROWS_DEF - 1, 0, 16'sh8000);
        queue_elem(0, 16'sh8000, 1'b1);
        queue_elem(KEY_DEPTH - 1, 16'sh0007, 1'b0);
        queue_elem(0, 16'sh0000, 1'b1);

        run_phase(0, 0, $urandom_range(1, 4), $urandom_range(1, 8), 25);
        run_phase(53, 0, MAX_ROWS_DEF, $urandom_range(1, 2), 25);
        run_phase(0, 53, $urandom_range(1, 4), $urandom_range(1, 8), 25);
        run_phase(25, 25, 2, $urandom_range(1, 16), 25);

        // receiver holds off while the sender keeps offering whole frames
        start_phase(0, 0, $urandom_range(2, 4), $urandom_range(1, 8));
        hold_request = 800;
        repeat (4) random_frame();
        wait_drained(0);
        start = words_queued;
        while (words_queued - start < 15) random_frame();

        wait_drained(END_CYCLES);
        $display("covered %0d input words over %0d register settings, clamped extremes included",
                 words_accepted, settings_used);
        $display("checked %0d row results from %0d frames, %0d frames with a missing key",
                 results_checked, frames_run, missing_frames);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(TIME_LIMIT);
        $display("timeout with %0d row results outstanding", row_results_due.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ssmvp_pkg.sv
rtl/sparse_scatter_matvec_projector.sv
tb/tb_top.sv
